>>> rtl/mrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the Modbus RTU response checker: word types, mode and status
// codes, CRC constants and the bytewise CRC-16 update. No dependencies.
package mrc_pkg;

	// Input modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Final status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_SIZE      = 3'd1;
	localparam logic [2:0] STAT_TIMEOUT   = 3'd2;
	localparam logic [2:0] STAT_BAD_SLAVE = 3'd3;
	localparam logic [2:0] STAT_BAD_CODE  = 3'd4;
	localparam logic [2:0] STAT_BAD_CRC   = 3'd5;

	// CRC-16, reflected
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Address, code and two CRC bytes around the payload
	localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

	// Register map
	localparam logic        REG_TIMEOUT   = 1'b0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] slave_id;
		logic [7:0] function_code;
		logic [7:0] data_length;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [2:0] status;
	} result_t;

	// Core to output stage: one result slot per processed word
	typedef struct packed {
		logic    valid;
		result_t data;
	} result_slot_t;

	// One byte through the reflected CRC, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/mrc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for command words and result words.
// Standalone; widths follow mrc_pkg field widths.
interface mrc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] slave_id;
	logic [7:0] function_code;
	logic [7:0] data_length;
	logic [7:0] rx_byte;

	modport source (output valid, mode, slave_id, function_code, data_length, rx_byte,
		input ready);
	modport sink (input valid, mode, slave_id, function_code, data_length, rx_byte,
		output ready);
endinterface

interface mrc_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] payload_byte;
	logic [2:0] status;

	modport source (output valid, kind, payload_byte, status, input ready);
	modport sink (input valid, kind, payload_byte, status, output ready);
endinterface
`default_nettype wire

>>> rtl/mrc_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// APB register block holding the timeout threshold.
// Depends on mrc_pkg.
module mrc_apb_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [15:0] timeout_ticks
);
	logic [15:0] timeout_q;
	logic        sel_timeout;

	// Register index is paddr[2]; byte lanes within a word are not decoded
	assign sel_timeout = (paddr[2] == mrc_pkg::REG_TIMEOUT);
	assign pready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= mrc_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && sel_timeout) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// Read back
	assign prdata        = sel_timeout ? {16'h0000, timeout_q} : 32'h0000_0000;
	assign timeout_ticks = timeout_q;
endmodule
`default_nettype wire

>>> rtl/mrc_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// Input register stage: captures one command word per cycle
// while in_ready is high. Depends on mrc_pkg.
module mrc_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire mrc_pkg::item_t in_item,
	output logic               in_ready,
	input  wire logic          advance,
	output logic               valid_s1,
	output mrc_pkg::item_t     item_s1
);
	logic accept;

	// Free when empty or when the held word moves on this cycle
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end
endmodule
`default_nettype wire

>>> rtl/mrc_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Frame checker state and per-word decision logic: address/code compare,
// CRC update, payload forwarding, timeout count. Depends on mrc_pkg.
module mrc_frame_core #(
	parameter int MAX_PAYLOAD = 252
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire mrc_pkg::item_t    item_s1,
	input  wire logic [15:0]       timeout_ticks,
	output mrc_pkg::result_slot_t  slot
);
	logic        busy_q,      busy_d;
	logic [7:0]  exp_slave_q, exp_slave_d;
	logic [7:0]  exp_code_q,  exp_code_d;
	logic [8:0]  frame_len_q, frame_len_d;
	logic [8:0]  count_q,     count_d;
	logic [15:0] crc_q,       crc_d;
	logic [7:0]  crc_low_q,   crc_low_d;
	logic        slave_mis_q, slave_mis_d;
	logic        code_mis_q,  code_mis_d;
	logic [15:0] idle_q,      idle_d;

	logic [15:0] crc_next;
	logic [9:0]  idx_plus2;
	logic [9:0]  frame_len_w;
	logic [15:0] idle_inc;

	assign crc_next    = mrc_pkg::crc_byte(crc_q, item_s1.rx_byte);
	assign idx_plus2   = {1'b0, count_q} + 10'd2;
	assign frame_len_w = {1'b0, frame_len_q};
	assign idle_inc    = (idle_q == mrc_pkg::IDLE_MAX) ? idle_q : idle_q + 16'd1;

	// Next state and result for the word in the input register
	always_comb begin
		busy_d      = busy_q;
		exp_slave_d = exp_slave_q;
		exp_code_d  = exp_code_q;
		frame_len_d = frame_len_q;
		count_d     = count_q;
		crc_d       = crc_q;
		crc_low_d   = crc_low_q;
		slave_mis_d = slave_mis_q;
		code_mis_d  = code_mis_q;
		idle_d      = idle_q;
		slot        = '0;

		case (item_s1.mode)
			mrc_pkg::MODE_START: begin
				busy_d = 1'b0;
				if (item_s1.data_length > 8'(MAX_PAYLOAD)) begin
					slot.valid       = 1'b1;
					slot.data.kind   = mrc_pkg::KIND_STATUS;
					slot.data.status = mrc_pkg::STAT_SIZE;
				end else begin
					busy_d      = 1'b1;
					exp_slave_d = item_s1.slave_id;
					exp_code_d  = item_s1.function_code;
					frame_len_d = {1'b0, item_s1.data_length} + mrc_pkg::FRAME_OVERHEAD;
					count_d     = '0;
					crc_d       = mrc_pkg::CRC_INIT;
					crc_low_d   = '0;
					slave_mis_d = 1'b0;
					code_mis_d  = 1'b0;
					idle_d      = '0;
				end
			end
			mrc_pkg::MODE_BYTE: begin
				if (busy_q) begin
					idle_d  = '0;
					count_d = count_q + 9'd1;
					if (count_q == 9'd0) begin
						slave_mis_d = (item_s1.rx_byte != exp_slave_q);
						crc_d       = crc_next;
					end else if (count_q == 9'd1) begin
						code_mis_d = (item_s1.rx_byte != exp_code_q);
						crc_d      = crc_next;
					end else if (idx_plus2 < frame_len_w) begin
						// Payload byte: forward and fold into the CRC
						crc_d                  = crc_next;
						slot.valid             = 1'b1;
						slot.data.kind         = mrc_pkg::KIND_PAYLOAD;
						slot.data.payload_byte = item_s1.rx_byte;
						slot.data.status       = mrc_pkg::STAT_OK;
					end else if (idx_plus2 == frame_len_w) begin
						crc_low_d = item_s1.rx_byte;
					end else begin
						// CRC high byte closes the frame
						busy_d         = 1'b0;
						slot.valid     = 1'b1;
						slot.data.kind = mrc_pkg::KIND_STATUS;
						if (slave_mis_q) begin
							slot.data.status = mrc_pkg::STAT_BAD_SLAVE;
						end else if (code_mis_q) begin
							slot.data.status = mrc_pkg::STAT_BAD_CODE;
						end else if (crc_low_q != crc_q[7:0] ||
								item_s1.rx_byte != crc_q[15:8]) begin
							slot.data.status = mrc_pkg::STAT_BAD_CRC;
						end else begin
							slot.data.status = mrc_pkg::STAT_OK;
						end
					end
				end
			end
			mrc_pkg::MODE_TICK: begin
				if (busy_q) begin
					idle_d = idle_inc;
					if (idle_inc >= timeout_ticks) begin
						busy_d           = 1'b0;
						slot.valid       = 1'b1;
						slot.data.kind   = mrc_pkg::KIND_STATUS;
						slot.data.status = mrc_pkg::STAT_TIMEOUT;
					end
				end
			end
			default: begin
				// unused mode: no effect
			end
		endcase
	end

	// Frame state, updated when the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			exp_slave_q <= '0;
			exp_code_q  <= '0;
			frame_len_q <= '0;
			count_q     <= '0;
			crc_q       <= mrc_pkg::CRC_INIT;
			crc_low_q   <= '0;
			slave_mis_q <= 1'b0;
			code_mis_q  <= 1'b0;
			idle_q      <= '0;
		end else if (advance) begin
			busy_q      <= busy_d;
			exp_slave_q <= exp_slave_d;
			exp_code_q  <= exp_code_d;
			frame_len_q <= frame_len_d;
			count_q     <= count_d;
			crc_q       <= crc_d;
			crc_low_q   <= crc_low_d;
			slave_mis_q <= slave_mis_d;
			code_mis_q  <= code_mis_d;
			idle_q      <= idle_d;
		end
	end
endmodule
`default_nettype wire

>>> rtl/mrc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// Result register: holds one result word until the receiver takes it and
// decides when the input register may advance. Depends on mrc_pkg.
module mrc_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire mrc_pkg::result_slot_t slot,
	output logic                  advance,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mrc_pkg::result_t      out_data
);
	logic free;

	// Slot is free when empty or being drained this cycle
	assign free    = !out_valid || out_ready;
	assign advance = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= advance && slot.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && slot.valid) begin
			out_data <= slot.data;
		end
	end
endmodule
`default_nettype wire

>>> rtl/modbus_rtu_response_checker_unit.sv
// Modbus RTU response checker.
// cmd channel: one word per cycle if ready. mode 0 arms a frame (slave_id,
// function_code, data_length), mode 1 delivers a received line byte,
// mode 2 is a timer tick. res channel: kind 0 forwards a payload byte,
// kind 1 gives the frame's final status; a word yields at most one result.
// A command word passes the input register, then the result register,
// before its result is valid on res. Throughput: one word per cycle
// while res is not stalled; the frame state, CRC update and status
// select are combinational between the two registers.
// A start with data_length above MAX_PAYLOAD answers with a size error at
// once; a start while a frame is open drops it. Bytes and ticks outside a
// frame give nothing. The idle count clears on every byte and times out at
// the APB register timeout_ticks (address 0, reset 2000).
// Reset: no frame open, both registers empty, timeout back to 2000.
// Stall: while res is held, the result register keeps its word, the input
// register fills once and then cmd.ready drops until res drains.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_response_checker_unit #(
	parameter int MAX_PAYLOAD = 252
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mrc_cmd_if.sink          cmd,
	mrc_res_if.source        res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	mrc_pkg::item_t        cmd_item;
	mrc_pkg::item_t        item_s1;
	mrc_pkg::result_slot_t slot;
	mrc_pkg::result_t      res_data;
	logic                  valid_s1;
	logic                  advance;
	logic [15:0]           timeout_ticks;

	assign cmd_item.mode          = cmd.mode;
	assign cmd_item.slave_id      = cmd.slave_id;
	assign cmd_item.function_code = cmd.function_code;
	assign cmd_item.data_length   = cmd.data_length;
	assign cmd_item.rx_byte       = cmd.rx_byte;

	mrc_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	mrc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_item  (cmd_item),
		.in_ready (cmd.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mrc_frame_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item_s1       (item_s1),
		.timeout_ticks (timeout_ticks),
		.slot          (slot)
	);

	mrc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.slot      (slot),
		.advance   (advance),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res_data)
	);

	assign res.kind         = res_data.kind;
	assign res.payload_byte = res_data.payload_byte;
	assign res.status       = res_data.status;
endmodule
`default_nettype wire

>>> rtl/mrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the response checker, bound to the top level.
// Depends on mrc_pkg and modbus_rtu_response_checker_unit.
module mrc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        res_kind,
	input wire logic [7:0]  res_payload_byte,
	input wire logic [2:0]  res_status,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata
);
	// A held result word stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
			$stable(res_payload_byte) && $stable(res_status))
		else $error("result word changed while stalled");

	// Input backpressure only comes from a stalled result
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("cmd not ready without a stalled result");

	// Payload words carry status ok
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == mrc_pkg::KIND_PAYLOAD |-> res_status == mrc_pkg::STAT_OK)
		else $error("payload word with nonzero status");

	// Status words carry a zero byte
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == mrc_pkg::KIND_STATUS |-> res_payload_byte == 8'h00)
		else $error("status word with nonzero byte");

	// Timeout register reads back what was written
	a_reg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=>
			paddr[2] || prdata[15:0] == $past(pwdata[15:0]))
		else $error("timeout register readback mismatch");
endmodule

bind modbus_rtu_response_checker_unit mrc_checker u_mrc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_kind         (res.kind),
	.res_payload_byte (res.payload_byte),
	.res_status       (res.status),
	.psel             (psel),
	.penable          (penable),
	.pwrite           (pwrite),
	.paddr            (paddr),
	.pwdata           (pwdata),
	.prdata           (prdata)
);
`default_nettype wire
